>>> rtl/core/sorted_priority_queue_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sorted priority queue
// Implication checks in the same cycle and in the next cycle.
// ----------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_QUEUE_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_ASSERT_SVH

`ifndef SYNTHESIS
`define SPQ_ASSERT_NOW(label, clk, rst_n, lhs, rhs) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
		else $error("assertion failed in sorted priority queue");
`define SPQ_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
		else $error("assertion failed in sorted priority queue");
`else
`define SPQ_ASSERT_NOW(label, clk, rst_n, lhs, rhs)
`define SPQ_ASSERT_NEXT(label, clk, rst_n, lhs, rhs)
`endif

`endif

>>> rtl/core/spq_pkg.sv
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Item types, operation and status codes, and default sizes.
// ----------------------------------------------------------------------------
package spq_pkg;

	localparam int VALUE_BITS     = 32;
	localparam int IN_WEIGHT_BITS = 16;
	localparam int COUNT_BITS     = 5;
	localparam int DEPTH_DEF      = 16;
	localparam int WEIGHT_DEF     = 16;

	localparam logic [COUNT_BITS-1:0] CAP_RESET = 5'd16;
	localparam logic signed [VALUE_BITS-1:0] MOST_NEG = 32'sh8000_0000;

	typedef enum logic [1:0] {
		OP_ENQ  = 2'd0,
		OP_DEQ  = 2'd1,
		OP_PEEK = 2'd2,
		OP_NOP  = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_OVER  = 2'd1,
		ST_UNDER = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_NEW,
		CELL_LEFT,
		CELL_RIGHT
	} cell_op_t;

	typedef struct packed {
		opcode_t                       opcode;
		logic signed [VALUE_BITS-1:0]     item_value;
		logic signed [IN_WEIGHT_BITS-1:0] item_weight;
	} spq_in_t;

	typedef struct packed {
		logic signed [VALUE_BITS-1:0] out_value;
		status_t                      status;
		logic [COUNT_BITS-1:0]        entry_count;
		logic                         is_empty;
		logic                         is_full;
	} spq_out_t;

endpackage

>>> rtl/core/spq_cell.sv
// ----------------------------------------------------------------------------
// Sorted priority queue cell
// One slot of the sorted chain: holds an entry, compares it against the
// incoming weight and loads the new item or a neighbor's entry.
// ----------------------------------------------------------------------------
module spq_cell #(
	parameter int WEIGHT_BITS = spq_pkg::WEIGHT_DEF
) (
	input  logic                                  clk,
	input  logic                                  occupied,
	input  spq_pkg::cell_op_t                     cell_op,
	input  logic signed [spq_pkg::VALUE_BITS-1:0] new_value,
	input  logic signed [WEIGHT_BITS-1:0]         new_weight,
	input  logic signed [spq_pkg::VALUE_BITS-1:0] left_value,
	input  logic signed [WEIGHT_BITS-1:0]         left_weight,
	input  logic signed [spq_pkg::VALUE_BITS-1:0] right_value,
	input  logic signed [WEIGHT_BITS-1:0]         right_weight,
	output logic signed [spq_pkg::VALUE_BITS-1:0] value,
	output logic signed [WEIGHT_BITS-1:0]         weight,
	output logic                                  ge
);
	import spq_pkg::*;

	logic signed [VALUE_BITS-1:0]  value_q;
	logic signed [WEIGHT_BITS-1:0] weight_q;

	always_ff @(posedge clk) begin
		unique case (cell_op)
			CELL_HOLD: begin
				value_q  <= value_q;
				weight_q <= weight_q;
			end
			CELL_NEW: begin
				value_q  <= new_value;
				weight_q <= new_weight;
			end
			CELL_LEFT: begin
				value_q  <= left_value;
				weight_q <= left_weight;
			end
			CELL_RIGHT: begin
				value_q  <= right_value;
				weight_q <= right_weight;
			end
		endcase
	end

	// The held entry stays ahead of a new item of equal or lower weight.
	assign ge     = occupied && (new_weight <= weight_q);
	assign value  = value_q;
	assign weight = weight_q;

endmodule

>>> rtl/core/sorted_priority_queue.sv
// ----------------------------------------------------------------------------
// Sorted priority queue
// The result of an item appears with done in the cycle after start.
// Throughput: one item per cycle; busy stays low, since every cell of the
// chain compares and shifts in the same cycle.
// Reset: count clears to zero and capacity returns to sixteen; slot contents
// are left as they are and are never read before being written.
// ----------------------------------------------------------------------------
module sorted_priority_queue #(
	parameter int DEPTH       = spq_pkg::DEPTH_DEF,
	parameter int WEIGHT_BITS = spq_pkg::WEIGHT_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  spq_pkg::spq_in_t              cmd,
	output logic                          done,
	output spq_pkg::spq_out_t             rsp,
	input  logic                          cfg_we,
	input  logic [spq_pkg::COUNT_BITS-1:0] cfg_wdata
);
	import spq_pkg::*;

	`include "sorted_priority_queue_assert.svh"

	logic [COUNT_BITS-1:0] cap_q;
	logic [COUNT_BITS-1:0] count_q;
	logic [COUNT_BITS-1:0] count_next;
	logic [COUNT_BITS-1:0] eff_cap;
	logic                  full_now;
	logic                  enq_ok;
	logic                  deq_ok;
	logic                  done_q;
	spq_out_t              rsp_q;
	spq_out_t              rsp_next;

	logic signed [WEIGHT_BITS-1:0] new_weight;
	logic [DEPTH-1:0]              ge;
	logic [DEPTH-1:0]              prev_ge;
	cell_op_t                      cell_op   [DEPTH];
	logic signed [VALUE_BITS-1:0]  val_a     [DEPTH];
	logic signed [WEIGHT_BITS-1:0] wt_a      [DEPTH];
	logic signed [VALUE_BITS-1:0]  left_val  [DEPTH];
	logic signed [WEIGHT_BITS-1:0] left_wt   [DEPTH];
	logic signed [VALUE_BITS-1:0]  right_val [DEPTH];
	logic signed [WEIGHT_BITS-1:0] right_wt  [DEPTH];

	assign busy = 1'b0;

	if (WEIGHT_BITS <= IN_WEIGHT_BITS) begin : g_wt_narrow
		assign new_weight = cmd.item_weight[WEIGHT_BITS-1:0];
	end else begin : g_wt_wide
		assign new_weight = {{(WEIGHT_BITS-IN_WEIGHT_BITS){1'b0}}, cmd.item_weight};
	end

	always_comb begin
		if (cap_q == '0) begin
			eff_cap = COUNT_BITS'(1);
		end else if (int'(cap_q) > DEPTH) begin
			eff_cap = COUNT_BITS'(DEPTH);
		end else begin
			eff_cap = cap_q;
		end
	end

	assign full_now = count_q >= eff_cap;
	assign enq_ok   = start && (cmd.opcode == OP_ENQ) && !full_now;
	assign deq_ok   = start && (cmd.opcode == OP_DEQ) && (count_q != '0);
	assign prev_ge  = {ge[DEPTH-2:0], 1'b1};

	always_comb begin
		priority if (enq_ok) begin
			count_next = count_q + COUNT_BITS'(1);
		end else if (deq_ok) begin
			count_next = count_q - COUNT_BITS'(1);
		end else begin
			count_next = count_q;
		end
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		if (i == 0) begin : g_head
			assign left_val[i] = cmd.item_value;
			assign left_wt[i]  = new_weight;
		end else begin : g_body
			assign left_val[i] = val_a[i-1];
			assign left_wt[i]  = wt_a[i-1];
		end

		if (i == DEPTH-1) begin : g_tail
			assign right_val[i] = val_a[i];
			assign right_wt[i]  = wt_a[i];
		end else begin : g_inner
			assign right_val[i] = val_a[i+1];
			assign right_wt[i]  = wt_a[i+1];
		end

		always_comb begin
			priority if (enq_ok && !ge[i]) begin
				cell_op[i] = prev_ge[i] ? CELL_NEW : CELL_LEFT;
			end else if (deq_ok && (i < DEPTH-1)) begin
				cell_op[i] = CELL_RIGHT;
			end else begin
				cell_op[i] = CELL_HOLD;
			end
		end

		spq_cell #(
			.WEIGHT_BITS (WEIGHT_BITS)
		) u_cell (
			.clk          (clk),
			.occupied     (int'(count_q) > i),
			.cell_op      (cell_op[i]),
			.new_value    (cmd.item_value),
			.new_weight   (new_weight),
			.left_value   (left_val[i]),
			.left_weight  (left_wt[i]),
			.right_value  (right_val[i]),
			.right_weight (right_wt[i]),
			.value        (val_a[i]),
			.weight       (wt_a[i]),
			.ge           (ge[i])
		);
	end

	always_comb begin
		rsp_next.out_value   = '0;
		rsp_next.status      = ST_OK;
		rsp_next.entry_count = count_next;
		rsp_next.is_empty    = count_next == '0;
		rsp_next.is_full     = count_next >= eff_cap;
		unique case (cmd.opcode)
			OP_ENQ: begin
				if (full_now) begin
					rsp_next.status = ST_OVER;
				end
			end
			OP_DEQ, OP_PEEK: begin
				if (count_q == '0) begin
					rsp_next.status    = ST_UNDER;
					rsp_next.out_value = MOST_NEG;
				end else begin
					rsp_next.out_value = val_a[0];
				end
			end
			OP_NOP: begin
				rsp_next.status = ST_OK;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q   <= CAP_RESET;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			if (start) begin
				count_q <= count_next;
			end
			done_q <= start;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rsp_q <= rsp_next;
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

	`SPQ_ASSERT_NEXT(a_start_done, clk, arst_n, start, done)
	`SPQ_ASSERT_NEXT(a_idle_count, clk, arst_n, !start, $stable(count_q))
	`SPQ_ASSERT_NOW(a_under_value, clk, arst_n, done && (rsp.status == ST_UNDER),
		(rsp.out_value == MOST_NEG) && rsp.is_empty)
	`SPQ_ASSERT_NOW(a_empty_flag, clk, arst_n, done, rsp.is_empty == (rsp.entry_count == '0))

endmodule
